@@ hdl/min_distance_iq_demapper_assert.svh @@
// Assertion macros for the minimum-distance I/Q demapper.
// Needs signals named clk and rst_n in the scope where a macro is used.
`ifndef MIN_DISTANCE_IQ_DEMAPPER_ASSERT_SVH
`define MIN_DISTANCE_IQ_DEMAPPER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MDD_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("demapper assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define MDD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("demapper assertion failed");

`endif

@@ hdl/mdd_pkg.sv @@
// Shared types and constants for the minimum-distance I/Q demapper.
// No dependencies; used by mdd_cell, mdd_ser and the top level.
package mdd_pkg;

    localparam int SMP_W          = 12;  // sample width, Q7.4
    localparam int PT_W           = 8;   // point coordinate width, Q3.4
    localparam int DIFF_W         = 13;  // sample minus point
    localparam int SQ_W           = 23;  // one squared difference
    localparam int DIST_W         = 24;  // sum of two squares
    localparam int IDX_W          = 4;   // point index bits
    localparam int POS_W          = 2;   // selects one bit of an index
    localparam int NB_W           = 3;   // bits_per_symbol register width
    localparam int PTS_W          = 5;   // point count, up to sixteen
    localparam int CFG_IDX_W      = 3;
    localparam int CFG_DATA_W     = 64;
    localparam int PT_PACK_W      = 16;  // one packed point in a table word
    localparam int PTS_PER_WORD   = 4;
    localparam int DEF_MAX_POINTS = 16;

    localparam logic [NB_W-1:0] NB_RESET = 3'd4;
    localparam logic [NB_W-1:0] NB_MIN   = 3'd1;
    localparam logic [NB_W-1:0] NB_MAX   = 3'd4;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_BITS_PER_SYMBOL = 3'd0,
        REG_POINT_TABLE_A   = 3'd1,
        REG_POINT_TABLE_B   = 3'd2,
        REG_POINT_TABLE_C   = 3'd3,
        REG_POINT_TABLE_D   = 3'd4
    } cfg_reg_e;

    typedef struct packed {
        logic signed [SMP_W-1:0] sample_i;
        logic signed [SMP_W-1:0] sample_q;
    } smp_t;

    typedef struct packed {
        logic bit_out;
        logic last_bit;
    } bits_t;

    // Q sits in the high byte, I in the low byte, as in the table words.
    typedef struct packed {
        logic signed [PT_W-1:0] q;
        logic signed [PT_W-1:0] i;
    } point_t;

    typedef struct packed {
        logic signed [SMP_W-1:0] smp_i;
        logic signed [SMP_W-1:0] smp_q;
        logic [DIST_W-1:0]       best_d;
        logic [IDX_W-1:0]        best_idx;
    } cell_bus_t;

    typedef struct packed {
        logic            load;
        logic [IDX_W-1:0] idx;
        logic [NB_W-1:0]  nb;
    } ser_ctl_t;

endpackage

@@ hdl/min_distance_iq_demapper.sv @@
// Top level of the minimum-distance I/Q demapper: config registers, cell chain,
// serializer and assertions. Depends on mdd_pkg, mdd_cell, mdd_ser and the assert header.
//
//   channel  | direction | handshake            | payload
//   ---------+-----------+----------------------+--------------------------------
//   smp      | in        | smp_valid/smp_stall  | smp_data: sample_i, sample_q
//   bit      | out       | bit_valid/bit_stall  | bit_data: bit_out, last_bit
//   cfg      | in        | cfg_we               | cfg_index, cfg_wdata
//
// A sample walks down MAX_POINTS cells, through the registered stages of each, and its index
// is then loaded into the serializer. The chain is a pipeline and the serializer
// sets the sustained rate: bits_per_symbol bits (one to four) per sample, next one taken as the last bit leaves.
// Reset empties the chain and serializer, clears the point tables to zero and sets
// bits_per_symbol to four. A stall on the bit channel backs up into the chain, which
// then raises smp_stall once its last stage holds a finished sample.
`include "min_distance_iq_demapper_assert.svh"

module min_distance_iq_demapper #(
    parameter int MAX_POINTS = mdd_pkg::DEF_MAX_POINTS
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             smp_valid,
    output logic                             smp_stall,
    input  mdd_pkg::smp_t                    smp_data,
    output logic                             bit_valid,
    input  logic                             bit_stall,
    output mdd_pkg::bits_t                   bit_data,
    input  logic                             cfg_we,
    input  logic [mdd_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [mdd_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

    logic [mdd_pkg::NB_W-1:0]  bps_reg;
    logic [mdd_pkg::NB_W-1:0]  nb;
    logic [mdd_pkg::PTS_W-1:0] npts;
    mdd_pkg::point_t           pts_reg [MAX_POINTS];
    logic [MAX_POINTS-1:0]     active;

    logic                      valid_chain [MAX_POINTS+1];
    mdd_pkg::cell_bus_t        bus_chain   [MAX_POINTS+1];

    logic                      tail_valid;
    logic                      ser_free;
    logic                      adv;
    mdd_pkg::ser_ctl_t         ser_ctl;

    // The bits_per_symbol register; out-of-range codes saturate to one or four.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bps_reg <= mdd_pkg::NB_RESET;
        end
        else if (cfg_we && (cfg_index == mdd_pkg::REG_BITS_PER_SYMBOL))
        begin
            bps_reg <= cfg_wdata[mdd_pkg::NB_W-1:0];
        end
    end

    always_comb
    begin
        priority if (bps_reg < mdd_pkg::NB_MIN)
        begin
            nb = mdd_pkg::NB_MIN;
        end
        else if (bps_reg > mdd_pkg::NB_MAX)
        begin
            nb = mdd_pkg::NB_MAX;
        end
        else
        begin
            nb = bps_reg;
        end
    end

    assign npts = mdd_pkg::PTS_W'(1) << nb;

    // Only the points that the chain really searches are stored. Each table word
    // carries four points; a word's points beyond MAX_POINTS are dropped.
    for (genvar p = 0; p < MAX_POINTS; p++)
    begin : g_pts
        localparam logic [mdd_pkg::CFG_IDX_W-1:0] TBL =
            mdd_pkg::CFG_IDX_W'(mdd_pkg::REG_POINT_TABLE_A + p / mdd_pkg::PTS_PER_WORD);
        localparam int LSB = mdd_pkg::PT_PACK_W * (p % mdd_pkg::PTS_PER_WORD);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                pts_reg[p] <= '0;
            end
            else if (cfg_we && (cfg_index == TBL))
            begin
                pts_reg[p] <= mdd_pkg::point_t'(cfg_wdata[LSB +: mdd_pkg::PT_PACK_W]);
            end
        end

        assign active[p] = (mdd_pkg::PTS_W'(p) < npts);
    end

    // The whole chain moves together; it holds only when its last stage has a
    // finished sample that the serializer cannot take yet.
    assign tail_valid = valid_chain[MAX_POINTS];
    assign adv        = !tail_valid || ser_free;
    assign smp_stall  = !adv;

    always_comb
    begin
        valid_chain[0]        = smp_valid;
        bus_chain[0].smp_i    = smp_data.sample_i;
        bus_chain[0].smp_q    = smp_data.sample_q;
        bus_chain[0].best_d   = '0;
        bus_chain[0].best_idx = '0;
    end

    for (genvar c = 0; c < MAX_POINTS; c++)
    begin : g_cell
        mdd_cell #(
            .CELL_IDX (c)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .adv       (adv),
            .active    (active[c]),
            .point     (pts_reg[c]),
            .valid_in  (valid_chain[c]),
            .bus_in    (bus_chain[c]),
            .valid_out (valid_chain[c+1]),
            .bus_out   (bus_chain[c+1])
        );
    end

    assign ser_ctl.load = tail_valid && ser_free;
    assign ser_ctl.idx  = bus_chain[MAX_POINTS].best_idx;
    assign ser_ctl.nb   = nb;

    mdd_ser u_ser (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ser_ctl),
        .free      (ser_free),
        .bit_valid (bit_valid),
        .bit_stall (bit_stall),
        .bit_data  (bit_data)
    );

    // A finished sample the serializer cannot take must hold off new samples.
    `MDD_ASSERT_SAME(a_backpressure, tail_valid && !ser_free, smp_stall)
    // A handed-over index shows up as a bit beat in the next cycle.
    `MDD_ASSERT_NEXT(a_load_shows, ser_ctl.load, bit_valid)
    // Within a symbol the bits follow each other without a gap.
    `MDD_ASSERT_NEXT(a_no_gap, bit_valid && !bit_stall && !bit_data.last_bit, bit_valid)
    // With one bit per symbol every beat is the last one.
    `MDD_ASSERT_SAME(a_single_bit, bit_valid && (nb == mdd_pkg::NB_MIN), bit_data.last_bit)

endmodule

@@ hdl/mdd_cell.sv @@
// One cell of the distance chain: holds nothing but its pipeline stages.
// Depends on mdd_pkg. Its point comes from the table registers in the top.
module mdd_cell #(
    parameter int CELL_IDX = 0
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               adv,
    input  logic               active,
    input  mdd_pkg::point_t    point,
    input  logic               valid_in,
    input  mdd_pkg::cell_bus_t bus_in,
    output logic               valid_out,
    output mdd_pkg::cell_bus_t bus_out
);

    logic signed [mdd_pkg::DIFF_W-1:0]   di;
    logic signed [mdd_pkg::DIFF_W-1:0]   dq;
    logic signed [2*mdd_pkg::DIFF_W-1:0] pi_full;
    logic signed [2*mdd_pkg::DIFF_W-1:0] pq_full;

    logic                         s1_valid_reg;
    mdd_pkg::cell_bus_t           s1_bus_reg;
    logic [mdd_pkg::SQ_W-1:0]     sqi_reg;
    logic [mdd_pkg::SQ_W-1:0]     sqq_reg;

    logic                         s2_valid_reg;
    mdd_pkg::cell_bus_t           s2_bus_reg;
    mdd_pkg::cell_bus_t           s2_bus_next;
    logic [mdd_pkg::DIST_W-1:0]   dist_sum;
    logic                         take;

    // First stage: the two squared differences.
    assign di      = mdd_pkg::DIFF_W'(bus_in.smp_i) - mdd_pkg::DIFF_W'(point.i);
    assign dq      = mdd_pkg::DIFF_W'(bus_in.smp_q) - mdd_pkg::DIFF_W'(point.q);
    assign pi_full = di * di;
    assign pq_full = dq * dq;

    // Second stage: sum and compare; a strict compare keeps the lower index on a tie.
    assign dist_sum = mdd_pkg::DIST_W'(sqi_reg) + mdd_pkg::DIST_W'(sqq_reg);
    assign take     = active && ((CELL_IDX == 0) || (dist_sum < s1_bus_reg.best_d));

    always_comb
    begin
        s2_bus_next = s1_bus_reg;
        if (take)
        begin
            s2_bus_next.best_d   = dist_sum;
            s2_bus_next.best_idx = mdd_pkg::IDX_W'(CELL_IDX);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg <= valid_in;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_bus_reg <= bus_in;
            sqi_reg    <= pi_full[mdd_pkg::SQ_W-1:0];
            sqq_reg    <= pq_full[mdd_pkg::SQ_W-1:0];
            s2_bus_reg <= s2_bus_next;
        end
    end

    assign valid_out = s2_valid_reg;
    assign bus_out   = s2_bus_reg;

endmodule

@@ hdl/mdd_ser.sv @@
// Serializer: sends the chosen point index one bit per beat, MSB first.
// Depends on mdd_pkg; loaded from the tail of the cell chain.
module mdd_ser (
    input  logic              clk,
    input  logic              rst_n,
    input  mdd_pkg::ser_ctl_t ctl,
    output logic              free,
    output logic              bit_valid,
    input  logic              bit_stall,
    output mdd_pkg::bits_t    bit_data
);

    logic                        valid_reg;
    logic [mdd_pkg::NB_W-1:0]    cnt_reg;
    logic [mdd_pkg::IDX_W-1:0]   idx_reg;
    logic [mdd_pkg::POS_W-1:0]   pos;
    logic                        fire;
    logic                        last;

    assign pos  = mdd_pkg::POS_W'(cnt_reg - 3'd1);
    assign fire = valid_reg && !bit_stall;
    assign last = (cnt_reg == 3'd1);
    assign free = !valid_reg || (fire && last);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            cnt_reg   <= '0;
        end
        else if (ctl.load)
        begin
            valid_reg <= 1'b1;
            cnt_reg   <= ctl.nb;
        end
        else if (fire)
        begin
            if (last)
            begin
                valid_reg <= 1'b0;
            end
            else
            begin
                cnt_reg <= cnt_reg - 3'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            idx_reg <= ctl.idx;
        end
    end

    assign bit_valid         = valid_reg;
    assign bit_data.bit_out  = idx_reg[pos];
    assign bit_data.last_bit = last;

endmodule
